// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every edge out of reset
`define SVTC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define SVTC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SVTC_ASSERT(label, clk, rst_n, prop, msg)
`define SVTC_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== design/svtc_pkg.sv =====
// ----------------------------------------------------------------------------
// svtc_pkg
// types, constants and elaboration-time tables of the voice tone chain
// ----------------------------------------------------------------------------
`default_nettype none

package svtc_pkg;

	localparam int SAMPLE_RATE_HZ = 48000;
	localparam int SINE_DEPTH     = 256;  // power of two
	localparam int SINE_IDX_W     = $clog2(SINE_DEPTH);
	localparam int SINE_ADDR_W    = $clog2(SINE_DEPTH + 1);

	localparam int OP_W   = 26;
	localparam int PROD_W = 2 * OP_W;
	localparam int RES_W  = 26;
	localparam int SUM_W  = 28;

	localparam logic [16:0] UNITY       = 17'd65536;
	localparam logic [15:0] WIDTH_MAX   = 16'd32768;
	localparam logic [10:0] DEPTH_MAX   = 11'd1024;
	localparam logic [16:0] AIR_LIFT    = 17'd85197;
	localparam logic [15:0] NOISE_SCALE = 16'd22938;
	localparam logic [15:0] RIGHT_NOISE = 16'd52429;
	localparam logic [31:0] LCG_MUL     = 32'd1664525;
	localparam logic [31:0] LCG_ADD     = 32'd1013904223;
	localparam logic [31:0] NOISE_SEED  = 32'h9E3779B9;
	localparam logic [23:0] ENV_MAX     = 24'h800000;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(8388607);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(8388608);

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TWO_PI_Q32  = 64'd26986075409;

	typedef enum logic [1:0] {SH_15, SH_16, SH_23} mul_shift_t;

	typedef struct packed {
		logic       issue;
		mul_shift_t shift;
	} mul_req_t;

	typedef enum logic [2:0] {
		REG_WIDTH, REG_DYN, REG_EXPR, REG_CUTOFF,
		REG_AIR, REG_NOISE, REG_DEPTH, REG_STEP
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_GDYN, ST_GEXPR, ST_GCUT, ST_GAIR, ST_GNOISE,
		ST_SIDE, ST_AMT, ST_TONE_L, ST_AIRLP_L, ST_SHELF_L,
		ST_TONE_R, ST_AIRLP_R, ST_SHELF_R, ST_ENV,
		ST_NLP, ST_NHP, ST_NAMT, ST_NSCL, ST_NRIGHT,
		ST_GAIN, ST_BMOD, ST_BGAIN, ST_OUT_L, ST_OUT_R
	} state_t;

	typedef logic [16:0] sine_tab_t [SINE_DEPTH+1];

	// 1 - exp(-x), x in Q32, result Q0.16 clamped to 1..65535
	function automatic logic [15:0] pole_coef(input logic [63:0] x_in);
		logic [63:0] x, y, term, e;
		logic signed [63:0] sum, c;
		int k;
		x = x_in;
		k = 0;
		for (int i = 0; i < 40; i++) begin
			if (x > Q30_ONE) begin
				x = x >> 1;
				k = k + 1;
			end
		end
		y = x >> 2;
		term = Q30_ONE;
		sum = $signed(Q30_ONE);
		term = ((term * y) >> 30) / 1;
		sum = sum - $signed(term);
		term = ((term * y) >> 30) / 2;
		sum = sum + $signed(term);
		term = ((term * y) >> 30) / 3;
		sum = sum - $signed(term);
		term = ((term * y) >> 30) / 4;
		sum = sum + $signed(term);
		term = ((term * y) >> 30) / 5;
		sum = sum - $signed(term);
		term = ((term * y) >> 30) / 6;
		sum = sum + $signed(term);
		e = (sum < 0) ? 64'd0 : 64'(sum);
		for (int i = 0; i < 40; i++) begin
			if (i < k)
				e = (e * e) >> 30;
		end
		if (e > Q30_ONE)
			e = Q30_ONE;
		c = $signed(((Q30_ONE - e) + 64'd8192) >> 14);
		if (c < 1)
			c = 1;
		if (c > 65535)
			c = 65535;
		return c[15:0];
	endfunction

	function automatic logic [16:0] sine_entry(input logic [63:0] i);
		logic [63:0] a, a2, term;
		logic signed [63:0] sum;
		a = (HALF_PI_Q30 * i) / SINE_DEPTH;
		a2 = (a * a) >> 30;
		term = a;
		sum = $signed(a);
		term = ((term * a2) >> 30) / 6;
		sum = sum - $signed(term);
		term = ((term * a2) >> 30) / 20;
		sum = sum + $signed(term);
		term = ((term * a2) >> 30) / 42;
		sum = sum - $signed(term);
		term = ((term * a2) >> 30) / 72;
		sum = sum + $signed(term);
		term = ((term * a2) >> 30) / 110;
		sum = sum - $signed(term);
		term = ((term * a2) >> 30) / 156;
		sum = sum + $signed(term);
		if (sum < 0)
			sum = 0;
		sum = (sum + 8192) >>> 14;
		if (sum > 65536)
			sum = 65536;
		return sum[16:0];
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t t;
		for (int i = 0; i <= SINE_DEPTH; i++)
			t[i] = sine_entry(64'(i));
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	localparam logic [63:0] X_FAST    = 64'd4294967296000 / (SAMPLE_RATE_HZ * 12);
	localparam logic [63:0] X_SLOW    = 64'd4294967296000 / (SAMPLE_RATE_HZ * 40);
	localparam logic [63:0] X_ATTACK  = 64'd4294967296000 / (SAMPLE_RATE_HZ * 15);
	localparam logic [63:0] X_RELEASE = 64'd4294967296000 / (SAMPLE_RATE_HZ * 220);
	localparam logic [63:0] X_AIR     = (TWO_PI_Q32 * 4000) / SAMPLE_RATE_HZ;
	localparam logic [63:0] X_NOISE   = (TWO_PI_Q32 * 2600) / SAMPLE_RATE_HZ;

	localparam logic [15:0] COEF_FAST    = pole_coef(X_FAST);
	localparam logic [15:0] COEF_SLOW    = pole_coef(X_SLOW);
	localparam logic [15:0] COEF_ATTACK  = pole_coef(X_ATTACK);
	localparam logic [15:0] COEF_RELEASE = pole_coef(X_RELEASE);
	localparam logic [15:0] COEF_AIR     = pole_coef(X_AIR);
	localparam logic [15:0] COEF_NOISE   = pole_coef(X_NOISE);

	function automatic logic signed [23:0] sat24(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] c;
		c = v;
		if (v > SAT_HI)
			c = SAT_HI;
		if (v < SAT_LO)
			c = SAT_LO;
		return c[23:0];
	endfunction

	// one-pole update: a step that rounds to zero still moves one lsb
	function automatic logic signed [SUM_W-1:0] glide_next(
		input logic signed [SUM_W-1:0] cur,
		input logic signed [OP_W-1:0]  d,
		input logic signed [RES_W-1:0] step
	);
		logic signed [RES_W-1:0] s;
		s = step;
		if (step == '0 && d != '0)
			s = d[OP_W-1] ? -RES_W'(1) : RES_W'(1);
		return cur + SUM_W'(s);
	endfunction

endpackage

`default_nettype wire

// ===== design/svtc_mul_unit.sv =====
// ----------------------------------------------------------------------------
// svtc_mul_unit
// shared signed multiplier with registered product and round-half-up shift
// ----------------------------------------------------------------------------
`default_nettype none

module svtc_mul_unit (
	input  wire logic                              clk,
	input  wire svtc_pkg::mul_req_t                req,
	input  wire logic signed [svtc_pkg::OP_W-1:0]  op_x,
	input  wire logic signed [svtc_pkg::OP_W-1:0]  op_y,
	output logic signed [svtc_pkg::RES_W-1:0]      res
);
	import svtc_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	mul_shift_t               shift_s1;
	logic signed [PROD_W-1:0] rnd;

	always_ff @(posedge clk) begin
		if (req.issue) begin
			prod_s1  <= op_x * op_y;
			shift_s1 <= req.shift;
		end
	end

	always_comb begin
		case (shift_s1)
			SH_15:   rnd = (prod_s1 + $signed(PROD_W'(1) << 14)) >>> 15;
			SH_16:   rnd = (prod_s1 + $signed(PROD_W'(1) << 15)) >>> 16;
			SH_23:   rnd = (prod_s1 + $signed(PROD_W'(1) << 22)) >>> 23;
			default: rnd = (prod_s1 + $signed(PROD_W'(1) << 15)) >>> 16;
		endcase
		res = rnd[RES_W-1:0];
	end

endmodule

`default_nettype wire

// ===== design/stereo_voice_tone_chain_core.sv =====
// ----------------------------------------------------------------------------
// stereo_voice_tone_chain_core
// stereo width, smoothed low-pass, air shelf, envelope, noise bed and
// breathing gain on one shared multiplier under a step sequencer
// ----------------------------------------------------------------------------
//  channel  direction  word contents (low bits first)
//  s_*      in         left_in[23:0], right_in[47:24]
//  m_*      out        left_out[23:0], right_out[47:24]
//  cfg_*    in         index 0..7, data up to 17 bits, write only
//
//  every step runs on the shared multiplier: multiply, then round,
//  post-add and write back
//  the noise bed and breathing each add steps to a word; s_tready is
//  high only between words
//  a finished word sits in the output register; the next word runs while it
//  waits and only its final write back holds until the register is free
//  reset loads the register defaults, clears the filters and seeds the noise
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_voice_tone_chain_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // left_in [23:0], right_in [47:24]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // left_out [23:0], right_out [47:24]
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [16:0] cfg_data
);
	import svtc_pkg::*;

	// configuration registers
	logic [15:0] width_q;
	logic [16:0] dyn_tgt_q, expr_tgt_q, air_tgt_q, noise_tgt_q;
	logic [15:0] cut_tgt_q;
	logic [10:0] depth_q;
	logic [15:0] bstep_q;

	// smoothers and filter state
	logic [16:0]        sdyn_q, sexpr_q, sair_q, snoise_q;
	logic [15:0]        scut_q;
	logic signed [23:0] tlp_q [2];
	logic signed [23:0] alp_q [2];
	logic [23:0]        env_q;
	logic signed [23:0] nlp_q;
	logic [31:0]        gen_q;
	logic [31:0]        phase_q;

	// per-word working registers
	state_t                   state_q, state_d;
	logic                     phase_bit_q;
	logic signed [23:0]       l_q, r_q;
	logic signed [OP_W-1:0]   d_q;
	logic [17:0]              amt_q;
	logic signed [RES_W-1:0]  t_q;
	logic [16:0]              gain_q;
	logic [17:0]              mod_q;
	logic signed [23:0]       out_l_q, out_r_q;
	logic                     out_valid_q;

	mul_req_t                 req;
	logic signed [OP_W-1:0]   op_x, op_y;
	logic signed [RES_W-1:0]  res;
	logic                     advance;

	// clamped register views
	logic [16:0] dyn_c, expr_c, air_c, noise_c;
	logic [15:0] width_c;
	logic [10:0] depth_c;

	// envelope detector and noise source
	logic [23:0]              abs_l, abs_r, level;
	logic signed [23:0]       white;

	// breathing sine lookup
	logic [1:0]               quad;
	logic [SINE_IDX_W-1:0]    sidx;
	logic [SINE_ADDR_W-1:0]   taddr;
	logic [16:0]              tval;
	logic signed [17:0]       sine_val;

	logic signed [SUM_W-1:0]  mid;

	assign dyn_c   = (dyn_tgt_q > UNITY) ? UNITY : dyn_tgt_q;
	assign expr_c  = (expr_tgt_q > UNITY) ? UNITY : expr_tgt_q;
	assign air_c   = (air_tgt_q > UNITY) ? UNITY : air_tgt_q;
	assign noise_c = (noise_tgt_q > UNITY) ? UNITY : noise_tgt_q;
	assign width_c = (width_q > WIDTH_MAX) ? WIDTH_MAX : width_q;
	assign depth_c = (depth_q > DEPTH_MAX) ? DEPTH_MAX : depth_q;

	assign abs_l = l_q[23] ? 24'(-l_q) : 24'(l_q);
	assign abs_r = r_q[23] ? 24'(-r_q) : 24'(r_q);
	assign level = 24'(({1'b0, abs_l} + {1'b0, abs_r}) >> 1);

	// 2*(s>>9) - 2^23 is the top 23 bits with the sign bit flipped
	assign white = $signed({~gen_q[31], gen_q[30:9], 1'b0});

	assign quad     = phase_q[31:30];
	assign sidx     = phase_q[29 -: SINE_IDX_W];
	assign taddr    = quad[0] ? SINE_ADDR_W'(SINE_DEPTH - int'(sidx)) : SINE_ADDR_W'(sidx);
	assign tval     = SINE_TAB[taddr];
	assign sine_val = quad[1] ? -$signed({1'b0, tval}) : $signed({1'b0, tval});

	assign mid = (SUM_W'(l_q) + SUM_W'(r_q) + SUM_W'(1)) >>> 1;

	// last write back waits while the previous word still sits at the output
	assign advance = phase_bit_q && !(state_q == ST_OUT_R && out_valid_q && !m_tready);

	svtc_mul_unit u_mul (
		.clk  (clk),
		.req  (req),
		.op_x (op_x),
		.op_y (op_y),
		.res  (res)
	);

	// next step
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (s_tvalid) state_d = ST_GDYN;
			ST_GDYN:    if (advance) state_d = ST_GEXPR;
			ST_GEXPR:   if (advance) state_d = ST_GCUT;
			ST_GCUT:    if (advance) state_d = ST_GAIR;
			ST_GAIR:    if (advance) state_d = ST_GNOISE;
			ST_GNOISE:  if (advance) state_d = ST_SIDE;
			ST_SIDE:    if (advance) state_d = ST_AMT;
			ST_AMT:     if (advance) state_d = ST_TONE_L;
			ST_TONE_L:  if (advance) state_d = ST_AIRLP_L;
			ST_AIRLP_L: if (advance) state_d = ST_SHELF_L;
			ST_SHELF_L: if (advance) state_d = ST_TONE_R;
			ST_TONE_R:  if (advance) state_d = ST_AIRLP_R;
			ST_AIRLP_R: if (advance) state_d = ST_SHELF_R;
			ST_SHELF_R: if (advance) state_d = ST_ENV;
			ST_ENV:     if (advance) state_d = (snoise_q != '0) ? ST_NLP : ST_GAIN;
			ST_NLP:     if (advance) state_d = ST_NHP;
			ST_NHP:     if (advance) state_d = ST_NAMT;
			ST_NAMT:    if (advance) state_d = ST_NSCL;
			ST_NSCL:    if (advance) state_d = ST_NRIGHT;
			ST_NRIGHT:  if (advance) state_d = ST_GAIN;
			ST_GAIN:    if (advance) state_d = (depth_q != '0) ? ST_BMOD : ST_OUT_L;
			ST_BMOD:    if (advance) state_d = ST_BGAIN;
			ST_BGAIN:   if (advance) state_d = ST_OUT_L;
			ST_OUT_L:   if (advance) state_d = ST_OUT_R;
			ST_OUT_R:   if (advance) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// multiplier operands for each step
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		req.issue = (state_q != ST_IDLE) && !phase_bit_q;
		req.shift = SH_16;
		op_x      = '0;
		op_y      = '0;
		case (state_q)
			ST_GDYN: begin
				op_x = $signed(OP_W'(dyn_c)) - $signed(OP_W'(sdyn_q));
				op_y = $signed(OP_W'(COEF_FAST));
			end
			ST_GEXPR: begin
				op_x = $signed(OP_W'(expr_c)) - $signed(OP_W'(sexpr_q));
				op_y = $signed(OP_W'(COEF_FAST));
			end
			ST_GCUT: begin
				op_x = $signed(OP_W'(cut_tgt_q)) - $signed(OP_W'(scut_q));
				op_y = $signed(OP_W'(COEF_SLOW));
			end
			ST_GAIR: begin
				op_x = $signed(OP_W'(air_c)) - $signed(OP_W'(sair_q));
				op_y = $signed(OP_W'(COEF_SLOW));
			end
			ST_GNOISE: begin
				op_x = $signed(OP_W'(noise_c)) - $signed(OP_W'(snoise_q));
				op_y = $signed(OP_W'(COEF_SLOW));
			end
			ST_SIDE: begin
				op_x      = OP_W'(l_q) - OP_W'(r_q);
				op_y      = $signed(OP_W'(width_c));
				req.shift = SH_15;
			end
			ST_AMT: begin
				op_x = $signed(OP_W'(sair_q));
				op_y = $signed(OP_W'(AIR_LIFT));
			end
			ST_TONE_L: begin
				op_x = OP_W'(l_q) - OP_W'(tlp_q[0]);
				op_y = $signed(OP_W'(scut_q));
			end
			ST_AIRLP_L: begin
				op_x = OP_W'(l_q) - OP_W'(alp_q[0]);
				op_y = $signed(OP_W'(COEF_AIR));
			end
			ST_SHELF_L: begin
				op_x = OP_W'(l_q) - OP_W'(alp_q[0]);
				op_y = $signed(OP_W'(amt_q));
			end
			ST_TONE_R: begin
				op_x = OP_W'(r_q) - OP_W'(tlp_q[1]);
				op_y = $signed(OP_W'(scut_q));
			end
			ST_AIRLP_R: begin
				op_x = OP_W'(r_q) - OP_W'(alp_q[1]);
				op_y = $signed(OP_W'(COEF_AIR));
			end
			ST_SHELF_R: begin
				op_x = OP_W'(r_q) - OP_W'(alp_q[1]);
				op_y = $signed(OP_W'(amt_q));
			end
			ST_ENV: begin
				op_x = $signed(OP_W'(level)) - $signed(OP_W'(env_q));
				op_y = $signed(OP_W'((level > env_q) ? COEF_ATTACK : COEF_RELEASE));
			end
			ST_NLP: begin
				op_x = OP_W'(white) - OP_W'(nlp_q);
				op_y = $signed(OP_W'(COEF_NOISE));
			end
			ST_NHP: begin
				op_x      = OP_W'(white) - OP_W'(nlp_q);
				op_y      = $signed(OP_W'(env_q));
				req.shift = SH_23;
			end
			ST_NAMT: begin
				op_x = OP_W'(t_q);
				op_y = $signed(OP_W'(snoise_q));
			end
			ST_NSCL: begin
				op_x = OP_W'(t_q);
				op_y = $signed(OP_W'(NOISE_SCALE));
			end
			ST_NRIGHT: begin
				op_x = OP_W'(t_q);
				op_y = $signed(OP_W'(RIGHT_NOISE));
			end
			ST_GAIN: begin
				op_x = $signed(OP_W'(sdyn_q));
				op_y = $signed(OP_W'(sexpr_q));
			end
			ST_BMOD: begin
				op_x = $signed(OP_W'(depth_c));
				op_y = OP_W'(sine_val);
			end
			ST_BGAIN: begin
				op_x = $signed(OP_W'(gain_q));
				op_y = $signed(OP_W'(mod_q));
			end
			ST_OUT_L: begin
				op_x = OP_W'(l_q);
				op_y = $signed(OP_W'(gain_q));
			end
			ST_OUT_R: begin
				op_x = OP_W'(r_q);
				op_y = $signed(OP_W'(gain_q));
			end
			default: begin
				op_x = '0;
				op_y = '0;
			end
		endcase
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_bit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req.issue)
				phase_bit_q <= 1'b1;
			else if (advance)
				phase_bit_q <= 1'b0;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 16'd16384;
			dyn_tgt_q   <= UNITY;
			expr_tgt_q  <= UNITY;
			cut_tgt_q   <= 16'd65535;
			air_tgt_q   <= '0;
			noise_tgt_q <= '0;
			depth_q     <= '0;
			bstep_q     <= 16'd8053;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WIDTH:  width_q     <= cfg_data[15:0];
				REG_DYN:    dyn_tgt_q   <= cfg_data;
				REG_EXPR:   expr_tgt_q  <= cfg_data;
				REG_CUTOFF: cut_tgt_q   <= cfg_data[15:0];
				REG_AIR:    air_tgt_q   <= cfg_data;
				REG_NOISE:  noise_tgt_q <= cfg_data;
				REG_DEPTH:  depth_q     <= cfg_data[10:0];
				REG_STEP:   bstep_q     <= cfg_data[15:0];
				default:    width_q     <= width_q;
			endcase
		end
	end

	// filter and smoother state, written back after each product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sdyn_q   <= '0;
			sexpr_q  <= '0;
			scut_q   <= '0;
			sair_q   <= '0;
			snoise_q <= '0;
			tlp_q[0] <= '0;
			tlp_q[1] <= '0;
			alp_q[0] <= '0;
			alp_q[1] <= '0;
			env_q    <= '0;
			nlp_q    <= '0;
			gen_q    <= NOISE_SEED;
			phase_q  <= '0;
		end else if (advance) begin
			case (state_q)
				ST_GDYN:   sdyn_q <= 17'(glide_next($signed(SUM_W'(sdyn_q)), d_q, res));
				ST_GEXPR:  sexpr_q <= 17'(glide_next($signed(SUM_W'(sexpr_q)), d_q, res));
				ST_GCUT:   scut_q <= 16'(glide_next($signed(SUM_W'(scut_q)), d_q, res));
				ST_GAIR:   sair_q <= 17'(glide_next($signed(SUM_W'(sair_q)), d_q, res));
				ST_GNOISE: snoise_q <= 17'(glide_next($signed(SUM_W'(snoise_q)), d_q, res));
				ST_TONE_L:  tlp_q[0] <= 24'(glide_next(SUM_W'(tlp_q[0]), d_q, res));
				ST_AIRLP_L: alp_q[0] <= 24'(glide_next(SUM_W'(alp_q[0]), d_q, res));
				ST_TONE_R:  tlp_q[1] <= 24'(glide_next(SUM_W'(tlp_q[1]), d_q, res));
				ST_AIRLP_R: alp_q[1] <= 24'(glide_next(SUM_W'(alp_q[1]), d_q, res));
				ST_ENV: begin
					env_q <= 24'(glide_next($signed(SUM_W'(env_q)), d_q, res));
					// generator runs only while the noise bed is on
					if (snoise_q != '0)
						gen_q <= gen_q * LCG_MUL + LCG_ADD;
				end
				ST_NLP: nlp_q <= 24'(glide_next(SUM_W'(nlp_q), d_q, res));
				ST_GAIN: begin
					// phase advances before the lookup and holds with breathing off
					if (depth_q != '0)
						phase_q <= phase_q + 32'(bstep_q);
				end
				default: gen_q <= gen_q;
			endcase
		end
	end

	// per-word samples and intermediates
	always_ff @(posedge clk) begin
		if (req.issue)
			d_q <= op_x;
		if (state_q == ST_IDLE && s_tvalid) begin
			l_q <= s_tdata[23:0];
			r_q <= s_tdata[47:24];
		end else if (advance) begin
			case (state_q)
				ST_SIDE: begin
					l_q <= sat24(mid + SUM_W'(res));
					r_q <= sat24(mid - SUM_W'(res));
				end
				ST_AMT:     amt_q <= 18'(res);
				ST_TONE_L:  l_q <= 24'(glide_next(SUM_W'(tlp_q[0]), d_q, res));
				ST_SHELF_L: l_q <= sat24(SUM_W'(l_q) + SUM_W'(res));
				ST_TONE_R:  r_q <= 24'(glide_next(SUM_W'(tlp_q[1]), d_q, res));
				ST_SHELF_R: r_q <= sat24(SUM_W'(r_q) + SUM_W'(res));
				ST_NHP:     t_q <= res;
				ST_NAMT:    t_q <= res;
				ST_NSCL: begin
					t_q <= res;
					l_q <= sat24(SUM_W'(l_q) + SUM_W'(res));
				end
				ST_NRIGHT:  r_q <= sat24(SUM_W'(r_q) - SUM_W'(res));
				ST_GAIN:    gain_q <= 17'(res);
				ST_BMOD:    mod_q <= 18'($signed(SUM_W'(UNITY)) + SUM_W'(res));
				ST_BGAIN:   gain_q <= 17'(res);
				ST_OUT_L:   l_q <= sat24(SUM_W'(res));
				ST_OUT_R: begin
					out_l_q <= l_q;
					out_r_q <= sat24(SUM_W'(res));
				end
				default:    amt_q <= amt_q;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && state_q == ST_OUT_R)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_r_q, out_l_q};

	`include "assert_macros.svh"

	`SVTC_ASSERT(a_gain_range, clk, arst_n, (sdyn_q <= UNITY) && (sexpr_q <= UNITY), "smoothed gain above unity")
	`SVTC_ASSERT(a_env_range, clk, arst_n, env_q <= ENV_MAX, "envelope above full scale")
	`SVTC_ASSERT(a_phase_hold, clk, arst_n, !$stable(phase_q) |-> $past(depth_q != '0), "breathing phase moved while off")
	`SVTC_ASSERT(a_noise_hold, clk, arst_n, !$stable(gen_q) |-> $past(snoise_q != '0), "noise generator moved while off")
	`SVTC_ASSERT_NEVER(a_busy_ready, clk, arst_n, s_tready && phase_bit_q, "input ready mid-step")

endmodule

`default_nettype wire
